FILE: rtl/rtp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table for the rectangular to polar converter.
// No dependencies; used by every module under rtl/.
package rtp_pkg;

    localparam int ITERATIONS = 20;
    localparam int FRAC_BITS  = 16;
    localparam int TABLE_FRAC = 24;
    localparam int OUT_FRAC   = 16;
    localparam int PRE_SHIFT  = 28;

    localparam int COORD_W   = 32;
    localparam int RADIUS_W  = 33;
    localparam int ANGLE_W   = 24;
    localparam int CORDIC_W  = 64;
    localparam int SUM_W     = 64;
    localparam int DEG90_Q16 = 5898240;

    // angle accumulator: sign plus 9 integer bits covers the table sum
    localparam int Z_W        = FRAC_BITS + 10;
    localparam int DOWN_SHIFT = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
    localparam int UP_SHIFT   = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
    localparam int ZQ_W       = Z_W + UP_SHIFT;
    localparam int ROUND_HALF = (DOWN_SHIFT > 0) ? (1 << (DOWN_SHIFT - 1)) : 0;
    localparam int TBL_SHIFT  = TABLE_FRAC - FRAC_BITS;
    localparam int TBL_HALF   = (TBL_SHIFT > 0) ? (1 << (TBL_SHIFT - 1)) : 0;

    // stage 0 input, 1 squares, 2 sum, then one root bit per stage
    localparam int SQRT_STEPS  = SUM_W / 2;
    localparam int NUM_STAGES  = 3 + SQRT_STEPS;
    localparam int LAST_STAGE  = NUM_STAGES - 1;
    localparam int ANGLE_STAGE = ITERATIONS + 1;

    typedef logic [LAST_STAGE:0] stage_vec_t;

    // atan(2^-i) in degrees, Q8.24, rounded to nearest
    function automatic logic [31:0] atan_q24(input int unsigned i);
        logic [31:0] t;
        case (i)
            0:       t = 32'd754974720;
            1:       t = 32'd445687602;
            2:       t = 32'd235489088;
            3:       t = 32'd119537938;
            4:       t = 32'd60000934;
            5:       t = 32'd30029717;
            6:       t = 32'd15018523;
            7:       t = 32'd7509720;
            8:       t = 32'd3754917;
            9:       t = 32'd1877466;
            10:      t = 32'd938734;
            11:      t = 32'd469367;
            12:      t = 32'd234684;
            13:      t = 32'd117342;
            14:      t = 32'd58671;
            15:      t = 32'd29335;
            16:      t = 32'd14668;
            17:      t = 32'd7334;
            18:      t = 32'd3667;
            19:      t = 32'd1833;
            20:      t = 32'd917;
            21:      t = 32'd458;
            22:      t = 32'd229;
            23:      t = 32'd115;
            24:      t = 32'd57;
            25:      t = 32'd29;
            26:      t = 32'd14;
            27:      t = 32'd7;
            28:      t = 32'd4;
            29:      t = 32'd2;
            30:      t = 32'd1;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

    // table entry rounded to FRAC_BITS fraction bits
    function automatic logic [Z_W-1:0] atan_entry(input int unsigned i);
        logic [32:0] t;
        t = {1'b0, atan_q24(i)} + 33'(TBL_HALF);
        return Z_W'(t >> TBL_SHIFT);
    endfunction

endpackage

FILE: rtl/rtp_cordic_pipe.sv
`timescale 1ns / 1ps
// Angle path: half-plane fold, vectoring CORDIC with one micro-rotation per stage,
// rounding, saturation and the zero-x cases. Depends on rtp_pkg.
module rtp_cordic_pipe (
    input  logic                               aclk,
    input  rtp_pkg::stage_vec_t                stage_load,
    input  logic signed [rtp_pkg::COORD_W-1:0] x_coord,
    input  logic signed [rtp_pkg::COORD_W-1:0] y_coord,
    output logic signed [rtp_pkg::ANGLE_W-1:0] angle_deg,
    output logic                               origin_flag
);

    localparam int IT   = rtp_pkg::ITERATIONS;
    localparam int CW   = rtp_pkg::CORDIC_W;
    localparam int ZW   = rtp_pkg::Z_W;
    localparam int ZQW  = rtp_pkg::ZQ_W;
    localparam int AST  = rtp_pkg::ANGLE_STAGE;
    localparam int LAST = rtp_pkg::LAST_STAGE;
    localparam logic signed [ZQW-1:0] POS90 = ZQW'(rtp_pkg::DEG90_Q16);
    localparam logic signed [ZQW-1:0] NEG90 = -POS90;
    localparam logic signed [rtp_pkg::ANGLE_W-1:0] ANG90 =
        rtp_pkg::ANGLE_W'(rtp_pkg::DEG90_Q16);

    logic signed [CW-1:0] cx_reg [0:IT];
    logic signed [CW-1:0] cy_reg [0:IT];
    logic signed [ZW-1:0] z_reg  [0:IT];
    logic                 xz_reg [0:IT];
    logic                 yz_reg [0:IT];
    logic                 yn_reg [0:IT];

    logic signed [rtp_pkg::ANGLE_W-1:0] ang_reg  [AST:LAST];
    logic                               flag_reg [AST:LAST];

    // fold negative x through the origin, then scale up
    logic signed [CW-1:0] xs, ys, fx, fy;

    always_comb begin
        xs = CW'(x_coord);
        ys = CW'(y_coord);
        if (x_coord[rtp_pkg::COORD_W-1]) begin
            fx = -xs;
            fy = -ys;
        end else begin
            fx = xs;
            fy = ys;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_load[0]) begin
            cx_reg[0] <= fx <<< rtp_pkg::PRE_SHIFT;
            cy_reg[0] <= fy <<< rtp_pkg::PRE_SHIFT;
            z_reg[0]  <= '0;
            xz_reg[0] <= (x_coord == '0);
            yz_reg[0] <= (y_coord == '0);
            yn_reg[0] <= y_coord[rtp_pkg::COORD_W-1];
        end
    end

    for (genvar i = 0; i < IT; i++) begin : g_rot
        localparam logic signed [ZW-1:0] ATAN = rtp_pkg::atan_entry(i);
        logic signed [CW-1:0] x_next, y_next;
        logic signed [ZW-1:0] z_next;

        always_comb begin
            if (!cy_reg[i][CW-1]) begin
                x_next = cx_reg[i] + (cy_reg[i] >>> i);
                y_next = cy_reg[i] - (cx_reg[i] >>> i);
                z_next = z_reg[i] + ATAN;
            end else begin
                x_next = cx_reg[i] - (cy_reg[i] >>> i);
                y_next = cy_reg[i] + (cx_reg[i] >>> i);
                z_next = z_reg[i] - ATAN;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_load[i+1]) begin
                cx_reg[i+1] <= x_next;
                cy_reg[i+1] <= y_next;
                z_reg[i+1]  <= z_next;
                xz_reg[i+1] <= xz_reg[i];
                yz_reg[i+1] <= yz_reg[i];
                yn_reg[i+1] <= yn_reg[i];
            end
        end
    end

    // bring to 16 fraction bits, clamp to +-90, then apply the zero-x cases
    logic signed [ZQW-1:0]              zq, zr, zs;
    logic signed [rtp_pkg::ANGLE_W-1:0] ang_next;
    logic                               flag_next;

    always_comb begin
        zq = ZQW'(z_reg[IT]);
        if (rtp_pkg::FRAC_BITS >= rtp_pkg::OUT_FRAC) begin
            zr = (zq + $signed(ZQW'(rtp_pkg::ROUND_HALF))) >>> rtp_pkg::DOWN_SHIFT;
        end else begin
            zr = zq <<< rtp_pkg::UP_SHIFT;
        end
        if (zr > POS90) begin
            zs = POS90;
        end else if (zr < NEG90) begin
            zs = NEG90;
        end else begin
            zs = zr;
        end
        flag_next = 1'b0;
        if (xz_reg[IT]) begin
            if (yz_reg[IT]) begin
                ang_next  = '0;
                flag_next = 1'b1;
            end else if (yn_reg[IT]) begin
                ang_next = -ANG90;
            end else begin
                ang_next = ANG90;
            end
        end else begin
            ang_next = zs[rtp_pkg::ANGLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_load[AST]) begin
            ang_reg[AST]  <= ang_next;
            flag_reg[AST] <= flag_next;
        end
    end

    // delay the finished angle to line up with the radius
    for (genvar k = AST + 1; k <= LAST; k++) begin : g_delay
        always_ff @(posedge aclk) begin
            if (stage_load[k]) begin
                ang_reg[k]  <= ang_reg[k-1];
                flag_reg[k] <= flag_reg[k-1];
            end
        end
    end

    assign angle_deg   = ang_reg[LAST];
    assign origin_flag = flag_reg[LAST];

endmodule

FILE: rtl/rtp_isqrt_pipe.sv
`timescale 1ns / 1ps
// Radius path: magnitudes, squares, sum, then a restoring square root that settles
// one result bit per stage. Depends on rtp_pkg.
module rtp_isqrt_pipe (
    input  logic                                 aclk,
    input  rtp_pkg::stage_vec_t                  stage_load,
    input  logic signed [rtp_pkg::COORD_W-1:0]   x_coord,
    input  logic signed [rtp_pkg::COORD_W-1:0]   y_coord,
    output logic        [rtp_pkg::RADIUS_W-1:0]  radius
);

    localparam int CDW  = rtp_pkg::COORD_W;
    localparam int SW   = rtp_pkg::SUM_W;
    localparam int LAST = rtp_pkg::LAST_STAGE;

    logic [CDW-1:0] ax_reg, ay_reg;
    logic [SW-1:0]  sqx_reg, sqy_reg;
    logic [SW-1:0]  n_reg    [2:LAST];
    logic [SW-1:0]  root_reg [2:LAST];

    logic [CDW-1:0] ax_next, ay_next;
    logic [SW-1:0]  sqx_next, sqy_next;

    // the most negative code wraps to its own magnitude as unsigned
    assign ax_next  = x_coord[CDW-1] ? CDW'(-x_coord) : CDW'(x_coord);
    assign ay_next  = y_coord[CDW-1] ? CDW'(-y_coord) : CDW'(y_coord);
    assign sqx_next = SW'(ax_reg) * SW'(ax_reg);
    assign sqy_next = SW'(ay_reg) * SW'(ay_reg);

    always_ff @(posedge aclk) begin
        if (stage_load[0]) begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
        end
        if (stage_load[1]) begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
        end
        if (stage_load[2]) begin
            n_reg[2]    <= sqx_reg + sqy_reg;
            root_reg[2] <= '0;
        end
    end

    for (genvar k = 0; k < rtp_pkg::SQRT_STEPS; k++) begin : g_step
        localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * k);
        logic [SW-1:0] trial, n_next, root_next;

        always_comb begin
            trial = root_reg[2+k] + BIT;
            if (n_reg[2+k] >= trial) begin
                n_next    = n_reg[2+k] - trial;
                root_next = (root_reg[2+k] >> 1) + BIT;
            end else begin
                n_next    = n_reg[2+k];
                root_next = root_reg[2+k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_load[3+k]) begin
                n_reg[3+k]    <= n_next;
                root_reg[3+k] <= root_next;
            end
        end
    end

    assign radius = root_reg[LAST][rtp_pkg::RADIUS_W-1:0];

endmodule

FILE: rtl/rect_to_polar_converter.sv
`timescale 1ns / 1ps
// Rectangular to polar converter: Q16.16 point in, Q17.16 radius and Q8.16 angle out.
// The square root settles one bit per stage, which sets the 35-stage depth.
// Throughput: one word per cycle while the output is not stalled; a stalled output
// freezes only full stages, empty stages keep filling. Reset clears the stage
// valid bits only.
// Depends on rtp_pkg, rtp_cordic_pipe and rtp_isqrt_pipe.
module rect_to_polar_converter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [rtp_pkg::COORD_W-1:0]   s_x_coord,
    input  logic signed [rtp_pkg::COORD_W-1:0]   s_y_coord,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic        [rtp_pkg::RADIUS_W-1:0]  m_radius,
    output logic signed [rtp_pkg::ANGLE_W-1:0]   m_angle_deg,
    output logic                                 m_origin_flag
);

    localparam int LAST = rtp_pkg::LAST_STAGE;

    rtp_pkg::stage_vec_t valid_reg, valid_next, stage_load;
    logic                out_free;

    // a stage loads when the output drains or the stage itself is empty
    always_comb begin
        out_free = !valid_reg[LAST] || m_ready;
        for (int i = 0; i <= LAST; i++) begin
            stage_load[i] = out_free || !valid_reg[i];
        end
        valid_next[0] = stage_load[0] ? s_valid : (valid_reg[0] && !stage_load[1]);
        for (int i = 1; i < LAST; i++) begin
            valid_next[i] = stage_load[i] ? valid_reg[i-1]
                                          : (valid_reg[i] && !stage_load[i+1]);
        end
        valid_next[LAST] = stage_load[LAST] ? valid_reg[LAST-1] : valid_reg[LAST];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_load[0];
    assign m_valid = valid_reg[LAST];

    rtp_cordic_pipe u_cordic (
        .aclk        (aclk),
        .stage_load  (stage_load),
        .x_coord     (s_x_coord),
        .y_coord     (s_y_coord),
        .angle_deg   (m_angle_deg),
        .origin_flag (m_origin_flag)
    );

    rtp_isqrt_pipe u_isqrt (
        .aclk       (aclk),
        .stage_load (stage_load),
        .x_coord    (s_x_coord),
        .y_coord    (s_y_coord),
        .radius     (m_radius)
    );

endmodule
